// ===== sv/median_image_filter_wrap_top_assert.svh =====
// ----------------------------------------------------------------------------
// Median image filter assertion macros
// Clocked implication forms shared by the checker.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_IMAGE_FILTER_WRAP_TOP_ASSERT_SVH
`define MEDIAN_IMAGE_FILTER_WRAP_TOP_ASSERT_SVH

// same-cycle implication
`define MIF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MIF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mif_pkg.sv =====
// ----------------------------------------------------------------------------
// Median image filter package
// Field widths, defaults, register indexes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package mif_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;
    localparam int DEF_MAX_WINDOW = 7;

    localparam int COL_W  = 6;
    localparam int ROW_W  = 6;
    localparam int CH_W   = 8;
    localparam int DIM_W  = 7;
    localparam int WIN_W  = 3;
    localparam int CFG_W  = 7;
    localparam int IDX_W  = 2;
    localparam int PIX_W  = 3 * CH_W;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;

    localparam int RED_STEPS = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int STEP_W    = $clog2(RED_STEPS);

    localparam logic [DIM_W-1:0] RST_WIDTH  = 7'd64;
    localparam logic [DIM_W-1:0] RST_HEIGHT = 7'd64;
    localparam logic [WIN_W-1:0] RST_WINDOW = 3'd3;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_FILTER = 1'b1;

    typedef enum logic [IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_WINDOW = 2'd2
    } mif_cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_BACK,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } mif_state_t;

endpackage

`default_nettype wire

// ===== sv/mif_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write and one read of the old word a cycle at one address, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mif_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  wire logic                              clk,
    input  wire logic                              we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                  wdata,
    output logic      [WIDTH-1:0]                  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ===== sv/median_image_filter_wrap_top.sv =====
// Load word: input is ready again on the next cycle.
// Filter word: col and row are reduced modulo the image size, then stepped back by d/2
// (d = window side); one image store read per window tap, a drain step, then the result.
// Input not ready from filter acceptance until the result is registered.
// Reset clears control state and the registers to 64, 64, 3; the image store is not cleared.
// ----------------------------------------------------------------------------
// Median image filter with wrapped edges
// Image store plus a sequencer that walks the window and a row of
// insertion cells per channel that keeps the lower half of the taps.
// ----------------------------------------------------------------------------
`default_nettype none

module median_image_filter_wrap_top
    import mif_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_wdata,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // col, row, in_red, in_green, in_blue, zero pad
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // req_type
    input  wire logic                   s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // out_red, out_green, out_blue
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int NW     = $clog2(MAX_WIDTH + 1);
    localparam int NH     = $clog2(MAX_HEIGHT + 1);
    localparam int DW     = $clog2(MAX_WINDOW + 1);
    localparam int SXW    = NW + COL_W;
    localparam int SYW    = NH + ROW_W;
    localparam int NCELL  = (MAX_WINDOW * MAX_WINDOW) / 2 + 1;
    localparam int KW     = (NCELL > 1) ? $clog2(NCELL) : 1;
    localparam int KEY_W  = CH_W + 1;
    localparam logic [KEY_W-1:0] KEY_HIGH = {1'b1, {CH_W{1'b0}}};

    mif_state_t state_reg, state_next;

    logic [DIM_W-1:0]  width_reg, height_reg;
    logic [WIN_W-1:0]  window_reg;

    logic [COL_W-1:0]  rx_reg, rx_next;
    logic [ROW_W-1:0]  ry_reg, ry_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [XW-1:0]     x_reg, x_next, x0_reg, x0_next;
    logic [YW-1:0]     y_reg, y_next;
    logic [DW-1:0]     i_reg, i_next, j_reg, j_next, cnt_reg, cnt_next;
    logic              rd_vld_reg, rd_vld_next;
    logic              out_vld_reg, out_vld_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic [KEY_W-1:0]  key_reg  [3][NCELL];
    logic [KEY_W-1:0]  key_next [3][NCELL];
    logic              gt       [3][NCELL];

    logic [NW-1:0]     w_eff;
    logic [NH-1:0]     h_eff;
    logic [DW-1:0]     d_eff, half, d_m1;
    logic [XW-1:0]     w_last;
    logic [YW-1:0]     h_last;
    logic [2*DW-1:0]   taps;
    logic [KW-1:0]     k_mid;
    logic [SXW-1:0]    sub_x;
    logic [SYW-1:0]    sub_y;
    logic [COL_W-1:0]  rx_red;
    logic [ROW_W-1:0]  ry_red;

    logic [COL_W-1:0]  in_col;
    logic [ROW_W-1:0]  in_row;
    logic              load_ok;
    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [PIX_W-1:0]  ram_wdata, ram_rdata;
    logic [KEY_W-1:0]  tap_key [3];

    assign in_col    = s_axis_tdata[COL_W-1:0];
    assign in_row    = s_axis_tdata[COL_W +: ROW_W];
    assign ram_wdata = s_axis_tdata[COL_W+ROW_W +: PIX_W];
    assign load_ok   = (int'(in_col) < MAX_WIDTH) && (int'(in_row) < MAX_HEIGHT);

    always_comb
    begin
        if (width_reg == '0)
            w_eff = NW'(1);
        else if (int'(width_reg) > MAX_WIDTH)
            w_eff = NW'(MAX_WIDTH);
        else
            w_eff = NW'(width_reg);

        if (height_reg == '0)
            h_eff = NH'(1);
        else if (int'(height_reg) > MAX_HEIGHT)
            h_eff = NH'(MAX_HEIGHT);
        else
            h_eff = NH'(height_reg);

        if (window_reg == '0)
            d_eff = DW'(1);
        else if (int'(window_reg) > MAX_WINDOW)
            d_eff = DW'(MAX_WINDOW);
        else
            d_eff = DW'(window_reg);
    end

    assign half   = d_eff >> 1;
    assign d_m1   = d_eff - DW'(1);
    assign w_last = XW'(w_eff - NW'(1));
    assign h_last = YW'(h_eff - NH'(1));
    assign taps   = (2*DW)'(d_eff) * (2*DW)'(d_eff);
    assign k_mid  = KW'(taps >> 1);

    assign sub_x  = SXW'(w_eff) << step_reg;
    assign sub_y  = SYW'(h_eff) << step_reg;
    assign rx_red = (SXW'(rx_reg) >= sub_x) ? rx_reg - COL_W'(sub_x) : rx_reg;
    assign ry_red = (SYW'(ry_reg) >= sub_y) ? ry_reg - ROW_W'(sub_y) : ry_reg;

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            tap_key[ch] = {1'b0, ram_rdata[ch*CH_W +: CH_W]};
            for (int c = 0; c < NCELL; c++)
            begin
                gt[ch][c] = key_reg[ch][c] > tap_key[ch];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            window_reg <= RST_WINDOW;
        end
        else if (cfg_we)
        begin
            case (mif_cfg_idx_t'(cfg_index))
                CFG_WIDTH:  width_reg  <= cfg_wdata[DIM_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_wdata[DIM_W-1:0];
                CFG_WINDOW: window_reg <= cfg_wdata[WIN_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_vld_reg  <= rd_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rx_reg       <= rx_next;
        ry_reg       <= ry_next;
        step_reg     <= step_next;
        x_reg        <= x_next;
        x0_reg       <= x0_next;
        y_reg        <= y_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
        key_reg      <= key_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        rx_next       = rx_reg;
        ry_next       = ry_reg;
        step_next     = step_reg;
        x_next        = x_reg;
        x0_next       = x0_reg;
        y_next        = y_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        cnt_next      = cnt_reg;
        out_data_next = out_data_reg;
        out_vld_next  = out_vld_reg;
        rd_vld_next   = 1'b0;
        key_next      = key_reg;
        ram_we        = 1'b0;
        ram_addr      = AW'(in_row) * AW'(MAX_WIDTH) + AW'(in_col);
        s_axis_tready = 1'b0;

        if (out_vld_reg && m_axis_tready)
            out_vld_next = 1'b0;

        // insert one tap, drop the largest
        if (rd_vld_reg)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                for (int c = 0; c < NCELL; c++)
                begin
                    if (c + 1 < NCELL && gt[ch][(c + 1) % NCELL])
                        key_next[ch][c] = key_reg[ch][(c + 1) % NCELL];
                    else if (gt[ch][c])
                        key_next[ch][c] = tap_key[ch];
                    else
                        key_next[ch][c] = key_reg[ch][c];
                end
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser == REQ_LOAD)
                    begin
                        ram_we = load_ok;
                    end
                    else
                    begin
                        rx_next    = in_col;
                        ry_next    = in_row;
                        step_next  = STEP_W'(RED_STEPS - 1);
                        state_next = ST_REDUCE;
                        for (int ch = 0; ch < 3; ch++)
                        begin
                            for (int c = 0; c < NCELL; c++)
                            begin
                                key_next[ch][c] = (KW'(c) <= k_mid) ? KEY_HIGH : '0;
                            end
                        end
                    end
                end
            end

            ST_REDUCE:
            begin
                rx_next   = rx_red;
                ry_next   = ry_red;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    x_next     = XW'(rx_red);
                    y_next     = YW'(ry_red);
                    cnt_next   = half;
                    state_next = ST_BACK;
                end
            end

            ST_BACK:
            begin
                if (cnt_reg == '0)
                begin
                    x0_next    = x_reg;
                    i_next     = '0;
                    j_next     = '0;
                    state_next = ST_SCAN;
                end
                else
                begin
                    x_next   = (x_reg == '0) ? w_last : x_reg - XW'(1);
                    y_next   = (y_reg == '0) ? h_last : y_reg - YW'(1);
                    cnt_next = cnt_reg - DW'(1);
                end
            end

            ST_SCAN:
            begin
                ram_addr    = AW'(y_reg) * AW'(MAX_WIDTH) + AW'(x_reg);
                rd_vld_next = 1'b1;
                if (j_reg == d_m1)
                begin
                    j_next = '0;
                    x_next = x0_reg;
                    y_next = (y_reg == h_last) ? '0 : y_reg + YW'(1);
                    i_next = i_reg + DW'(1);
                    if (i_reg == d_m1)
                        state_next = ST_DRAIN;
                end
                else
                begin
                    j_next = j_reg + DW'(1);
                    x_next = (x_reg == w_last) ? '0 : x_reg + XW'(1);
                end
            end

            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_vld_reg || m_axis_tready)
                begin
                    out_data_next = {key_reg[2][0][CH_W-1:0],
                                     key_reg[1][0][CH_W-1:0],
                                     key_reg[0][0][CH_W-1:0]};
                    out_vld_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    mif_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== sv/mif_checker.sv =====
// ----------------------------------------------------------------------------
// Median image filter port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "median_image_filter_wrap_top_assert.svh"

module mif_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic        s_axis_tuser,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [23:0] m_axis_tdata
);

    `MIF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")

    `MIF_ASSERT_NEXT(a_load_ready, s_axis_tvalid && s_axis_tready && !s_axis_tuser, s_axis_tready, "load word left input not ready")

    `MIF_ASSERT_NEXT(a_filter_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser, !s_axis_tready, "input ready right after filter word")

    `MIF_ASSERT_NOW(a_result_origin, $rose(m_axis_tvalid), $past(!s_axis_tready), "result raised outside a filter run")

endmodule

bind median_image_filter_wrap_top mif_checker u_mif_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
